// ----- sv/hldx_pkg.sv -----
// ----------------------------------------------------------------------------
// hldx_pkg
// Shared types and constants of the header/length deframer with XOR check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hldx_pkg;

  localparam int unsigned BufferDepthDef = 128;

  // frame byte that carries the type
  localparam int unsigned TypeIndex      = 3;
  // bytes between header and length byte
  localparam logic [8:0]  PreLengthBytes = 9'd3;

  // configuration port
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [1:0] RegHeaderByte     = 2'd0;
  localparam logic [1:0] RegExpectedLength = 2'd1;
  localparam logic [1:0] RegExpectedType   = 2'd2;

  localparam logic [7:0] HeaderByteRst     = 8'hBB;
  localparam logic [7:0] ExpectedLengthRst = 8'd61;
  localparam logic [7:0] ExpectedTypeRst   = 8'h04;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] expected_length;
    logic [7:0] expected_type;
  } cfg_t;

  typedef struct packed {
    logic       store_valid;
    logic [6:0] store_index;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       checksum_ok;
    logic       frame_accepted;
  } res_t;

endpackage

// ----- sv/hldx_ifs.sv -----
// ----------------------------------------------------------------------------
// hldx channel interfaces
// Valid/ready channels for received bytes and per-byte results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hldx_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hldx_res_if;
  logic       valid;
  logic       ready;
  logic       store_valid;
  logic [6:0] store_index;
  logic       frame_done;
  logic [7:0] frame_length;
  logic       checksum_ok;
  logic       frame_accepted;

  modport source (output valid, output store_valid, output store_index,
                  output frame_done, output frame_length, output checksum_ok,
                  output frame_accepted, input ready);
  modport sink   (input valid, input store_valid, input store_index,
                  input frame_done, input frame_length, input checksum_ok,
                  input frame_accepted, output ready);
endinterface

// ----- sv/hldx_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hldx_cfg_regs
// APB register file: header byte, expected length, expected type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hldx_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hldx_pkg::ApbAddrW-1:0]  paddr,
  input  logic [hldx_pkg::ApbDataW-1:0]  pwdata,
  output logic [hldx_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output hldx_pkg::cfg_t                 cfg_o
);

  hldx_pkg::cfg_t cfg_q;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte     <= hldx_pkg::HeaderByteRst;
      cfg_q.expected_length <= hldx_pkg::ExpectedLengthRst;
      cfg_q.expected_type   <= hldx_pkg::ExpectedTypeRst;
    end else if (wr_en) begin
      case (reg_idx)
        hldx_pkg::RegHeaderByte:     cfg_q.header_byte     <= pwdata[7:0];
        hldx_pkg::RegExpectedLength: cfg_q.expected_length <= pwdata[7:0];
        hldx_pkg::RegExpectedType:   cfg_q.expected_type   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      hldx_pkg::RegHeaderByte:     prdata[7:0] = cfg_q.header_byte;
      hldx_pkg::RegExpectedLength: prdata[7:0] = cfg_q.expected_length;
      hldx_pkg::RegExpectedType:   prdata[7:0] = cfg_q.expected_type;
      default:                     prdata      = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/hldx_engine.sv -----
// ----------------------------------------------------------------------------
// hldx_engine
// Frame tracking state and per-byte result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hldx_engine #(
  parameter int unsigned BUFFER_DEPTH = hldx_pkg::BufferDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  hldx_pkg::cfg_t cfg_i,
  output hldx_pkg::res_t res_o
);

  localparam int unsigned PosW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CmpW = (PosW > 8) ? PosW : 8;

  logic            awaiting_q, awaiting_d;
  logic [8:0]      remain_q, remain_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      type_q, type_d;

  logic            idle, start, active, can_store, done;
  logic [PosW-1:0] pos_cur;
  logic [7:0]      xor_cur, type_cur;
  logic [8:0]      remain_dec;

  assign idle    = (remain_q == '0) && !awaiting_q;
  assign start   = idle && (byte_i == cfg_i.header_byte);
  assign active  = start || !idle;

  // a header restarts the frame buffer
  assign pos_cur  = start ? '0 : pos_q;
  assign xor_cur  = start ? '0 : xor_q;
  assign type_cur = start ? '0 : type_q;

  assign can_store  = active && (pos_cur < PosW'(BUFFER_DEPTH));
  assign remain_dec = remain_q - 9'd1;

  always_comb begin
    pos_d      = can_store ? pos_cur + PosW'(1) : pos_cur;
    xor_d      = can_store ? (xor_cur ^ byte_i) : xor_cur;
    type_d     = (can_store && pos_cur == PosW'(hldx_pkg::TypeIndex)) ? byte_i : type_cur;
    awaiting_d = awaiting_q;
    remain_d   = remain_q;
    done       = 1'b0;
    if (start) begin
      remain_d   = hldx_pkg::PreLengthBytes;
      awaiting_d = 1'b1;
    end else if (!idle && remain_q == '0) begin
      // length byte
      remain_d   = {1'b0, byte_i} + 9'd1;
      awaiting_d = 1'b0;
    end else if (!idle) begin
      remain_d = remain_dec;
      done     = (remain_dec == '0) && !awaiting_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      remain_q   <= '0;
      pos_q      <= '0;
      xor_q      <= '0;
      type_q     <= '0;
    end else if (step_i) begin
      awaiting_q <= awaiting_d;
      remain_q   <= remain_d;
      pos_q      <= pos_d;
      xor_q      <= xor_d;
      type_q     <= type_d;
    end
  end

  always_comb begin
    res_o.store_valid    = can_store;
    res_o.store_index    = can_store ? 7'(pos_cur) : 7'd0;
    res_o.frame_done     = done;
    res_o.frame_length   = done ? 8'(pos_d) : 8'd0;
    res_o.checksum_ok    = done && (xor_d == 8'd0);
    res_o.frame_accepted = done && (xor_d == 8'd0)
                           && (CmpW'(pos_d) == CmpW'(cfg_i.expected_length))
                           && (type_d == cfg_i.expected_type);
  end

endmodule

// ----- sv/header_length_deframer_xor_core.sv -----
// ----------------------------------------------------------------------------
// header_length_deframer_xor_core
// Header/length serial deframer with XOR checksum and frame acceptance.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                     handshake
//   rx_i     in   rx_byte                                     valid/ready
//   res_o    out  store_valid, store_index, frame_done,       valid/ready
//                 frame_length, checksum_ok, frame_accepted
//   apb      in   header_byte, expected_length, expected_type psel/penable
//
// One item per cycle sustained while res_o is ready; each result passes through
// the input register, then the result register; frame state steps on that move.
// Reset is asynchronous, active low, and returns the deframer to idle.
// A stalled result holds in the result register; the input register still
// takes one more item, then ready drops until the result drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module header_length_deframer_xor_core #(
  parameter int unsigned BUFFER_DEPTH = hldx_pkg::BufferDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hldx_rx_if.sink                       rx_i,
  hldx_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hldx_pkg::ApbAddrW-1:0] paddr,
  input  logic [hldx_pkg::ApbDataW-1:0] pwdata,
  output logic [hldx_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  hldx_pkg::cfg_t cfg;
  hldx_pkg::res_t res_comb;
  hldx_pkg::res_t res_q;
  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           out_valid_q;
  logic           advance;

  hldx_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hldx_engine #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res_comb)
  );

  // item moves from input register to result register
  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.store_valid    = res_q.store_valid;
  assign res_o.store_index    = res_q.store_index;
  assign res_o.frame_done     = res_q.frame_done;
  assign res_o.frame_length   = res_q.frame_length;
  assign res_o.checksum_ok    = res_q.checksum_ok;
  assign res_o.frame_accepted = res_q.frame_accepted;

endmodule

// ----- sv/hldx_checker.sv -----
// ----------------------------------------------------------------------------
// hldx_checker
// Port-level checks on the deframer result channel and config port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hldx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid,
  input logic       res_ready,
  input logic       store_valid,
  input logic [6:0] store_index,
  input logic       frame_done,
  input logic [7:0] frame_length,
  input logic       checksum_ok,
  input logic       frame_accepted,
  input logic       pready
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(store_valid)
      && $stable(store_index) && $stable(frame_done) && $stable(frame_length)
      && $stable(checksum_ok) && $stable(frame_accepted))
    else $error("result changed while stalled");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !frame_done |-> frame_length == 8'd0 && !checksum_ok
      && !frame_accepted)
    else $error("frame fields set without frame_done");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !store_valid |-> store_index == 7'd0)
    else $error("store_index set without store_valid");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && frame_accepted |-> frame_done && checksum_ok && pready)
    else $error("frame accepted without good checksum");

endmodule

bind header_length_deframer_xor_core hldx_checker u_hldx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .store_valid    (res_o.store_valid),
  .store_index    (res_o.store_index),
  .frame_done     (res_o.frame_done),
  .frame_length   (res_o.frame_length),
  .checksum_ok    (res_o.checksum_ok),
  .frame_accepted (res_o.frame_accepted),
  .pready         (pready)
);
